// File: hdl/assert_macros.svh
// Assertion helpers for the heating curve controller.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define HCSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen.
`define HCSC_NEVER(lbl, expr, msg) `HCSC_ASSERT(lbl, !(expr), msg)

`endif

// File: hdl/hcsc_pkg.sv
// Shared types, constants and curve tables for the heating curve controller.
// No dependencies.
`timescale 1ns / 1ps

package hcsc_pkg;

  localparam int CURVE_POINTS = 11;
  localparam int IDX_W        = $clog2(CURVE_POINTS);
  localparam int CNT_W        = $clog2(CURVE_POINTS + 1);

  typedef logic signed [15:0] temp_t;
  typedef logic signed [23:0] dnum_t;

  localparam temp_t MARKER     = -16'sd25344;
  localparam int    ADAPT_BAND = 128;
  localparam int    ADAPT_STEP = 26;

  localparam int DEN_W      = 7;
  localparam int DIV_PHASES = 3;                 // multiply, remainder, fix-up
  localparam logic [DEN_W-1:0] DEN_SEG = 7'd5;   // 1280 = 256 * 5
  localparam logic [DEN_W-1:0] DEN_AVG = 7'd81;
  localparam logic [DEN_W-1:0] DEN_RED = 7'd10;

  // reciprocals floor(2^25 / den) for the biased 25-bit dividend
  localparam int REC_SHIFT = 25;
  localparam int REC_W     = 23;
  localparam logic [REC_W-1:0] REC_SEG = 23'd6710886;
  localparam logic [REC_W-1:0] REC_AVG = 23'd414252;
  localparam logic [REC_W-1:0] REC_RED = 23'd3355443;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_SETPOINT = 2'd1,
    REG_HYST     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    VALVE_NONE = 2'd0,
    VALVE_UP   = 2'd1,
    VALVE_DOWN = 2'd2
  } valve_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_ADAPT = 1'b1
  } req_t;

  typedef enum logic {
    MODE_AUTO   = 1'b0,
    MODE_MANUAL = 1'b1
  } mode_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
    dnum_t            num;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    dnum_t quo;
  } div_rsp_t;

  // Outdoor breakpoint i: -30 + 5*i degrees
  function automatic temp_t breakpoint(input logic [IDX_W-1:0] i);
    int v;
    v = (-30 + 5 * int'(i)) * 256;
    return temp_t'(v);
  endfunction

  // Supply temperature of a point after reset
  function automatic temp_t base_supply(input logic [IDX_W-1:0] i);
    int d;
    unique case (int'(i))
      0:       d = 40;
      1:       d = 38;
      2:       d = 34;
      3:       d = 34;
      4:       d = 32;
      5:       d = 30;
      6:       d = 28;
      7:       d = 25;
      8:       d = 23;
      9:       d = 21;
      default: d = 20;
    endcase
    return temp_t'(d * 256);
  endfunction

endpackage

// File: hdl/hcsc_div.sv
// Floor division of a signed value by a small constant: reciprocal multiply
// plus one compare-and-subtract fix-up. Depends on hcsc_pkg.
`timescale 1ns / 1ps

module hcsc_div import hcsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                      busy_r;
  logic                      done_r;
  logic [1:0]                ph_r;
  logic [24:0]               n_r;
  logic [REC_W-1:0]          m_r;
  logic [DEN_W-1:0]          den_r;
  logic [REC_SHIFT+REC_W-1:0] prod_r;
  logic [REC_W-1:0]          q_r;
  logic [DEN_W:0]            rem_r;
  logic [23:0]               quo_r;

  logic [24:0]      biased;
  logic [REC_W-1:0] recip;
  logic [REC_W-1:0] q_nxt;
  logic [24:0]      rem_nxt;
  logic             fix;

  // bias by den * 2^17 so the dividend is non-negative
  assign biased = {req.num[23], req.num} + ({18'd0, req.den} << 17);

  always_comb begin
    unique case (req.den)
      DEN_SEG: recip = REC_SEG;
      DEN_AVG: recip = REC_AVG;
      default: recip = REC_RED;
    endcase
  end

  // estimate is the true quotient or one below it
  assign q_nxt   = prod_r[REC_SHIFT +: REC_W];
  assign rem_nxt = n_r - ({2'b00, q_nxt} * {18'd0, den_r});
  assign fix     = (rem_r >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= biased;
      m_r   <= recip;
      den_r <= req.den;
    end
    prod_r <= {{REC_W{1'b0}}, n_r} * {{REC_SHIFT{1'b0}}, m_r};
    q_r    <= q_nxt;
    rem_r  <= rem_nxt[DEN_W:0];
    quo_r  <= {1'b0, q_r} + {23'd0, fix} - 24'h020000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= busy_r && (ph_r == 2'(DIV_PHASES - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'(DIV_PHASES - 1)) busy_r <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = dnum_t'(quo_r);

endmodule

// File: hdl/heating_curve_supply_controller.sv
// Heating curve supply controller: curve and averages in two registered-read RAMs.
// Control tick: segment and average divisions between points, average only at or
// below the first, none above; hours 6 and 7 add a divider pass. Manual tick skips
// the curve; adapt event walks every point. One item in flight: next item accepted
// the cycle after its result loads; a held result delays the load. Sync active-low
// reset: default curve, averages unseen, configuration registers to defaults.
`timescale 1ns / 1ps

module heating_curve_supply_controller import hcsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  temp_t       in_outdoor_temp,
  input  temp_t       in_indoor_temp,
  input  temp_t       in_supply_temp,
  input  logic [4:0]  in_hour_of_day,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_valve_step,
  output temp_t       out_supply_target,
  output logic        out_acted
);

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_LAST_W, S_LAST, S_A_W, S_A, S_B_W, S_B, S_MUL, S_SEG_GO,
    S_SEG_DIV, S_AVG_W, S_AVG, S_AVG_DIV, S_RED, S_RED_DIV, S_VALVE,
    S_AD_W, S_AD, S_DONE
  } state_t;

  // configuration registers
  mode_t       mode_r;
  temp_t       setpoint_r;
  logic [14:0] hyst_r;

  state_t           state_r;
  logic [IDX_W-1:0] addr_r;
  logic [CNT_W-1:0] pos_r;
  temp_t            outd_r, ind_r, sup_meas_r;
  logic [4:0]       hour_r;
  temp_t            last_r, y1_r, target_r, reduced_r;
  logic signed [16:0] dy_r;
  logic [10:0]      dx_r;
  logic signed [28:0] prod_r;
  valve_t           step_r;
  logic             acted_r;
  div_req_t         div_req_r;
  div_rsp_t         div_rsp;

  logic   out_valid_r;
  valve_t out_step_r;
  temp_t  out_target_r;
  logic   out_acted_r;

  // curve RAMs; an entry without its valid bit reads as its reset value
  temp_t sup_mem [CURVE_POINTS];
  temp_t avg_mem [CURVE_POINTS];
  logic [CURVE_POINTS-1:0] sup_vld_r, seen_r;
  temp_t            sup_rd_r, avg_rd_r;
  logic             sup_vld_rd_r, seen_rd_r;
  logic [IDX_W-1:0] rd_addr_r;

  temp_t sup_rd, avg_rd;
  logic  sup_we, avg_we;
  temp_t sup_wdata, avg_wdata;

  logic [CNT_W-1:0] below_cnt;
  logic             above;
  logic [IDX_W-1:0] pos_idx;
  logic             morning;
  logic             div_go;

  hcsc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req_r),
    .rsp (div_rsp)
  );

  // number of breakpoints strictly below the outdoor temperature
  always_comb begin
    below_cnt = '0;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      if (breakpoint(IDX_W'(i)) < in_outdoor_temp) below_cnt = below_cnt + CNT_W'(1);
    end
  end

  assign above   = (pos_r == CNT_W'(CURVE_POINTS));
  assign pos_idx = pos_r[IDX_W-1:0];
  assign morning = (hour_r == 5'd6) || (hour_r == 5'd7);

  assign sup_rd = sup_vld_rd_r ? sup_rd_r : base_supply(rd_addr_r);
  assign avg_rd = seen_rd_r ? avg_rd_r : MARKER;

  // adapt one point 0.1 degree: up if average > setpoint+0.5, down if < setpoint-0.5
  logic signed [16:0] ad_err, ad_mag, ad_sum;
  always_comb begin
    ad_err = {setpoint_r[15], setpoint_r} - {avg_rd[15], avg_rd};
    ad_mag = ad_err[16] ? -ad_err : ad_err;
    ad_sum = {sup_rd[15], sup_rd};
    if (ad_mag > 17'sd128) begin
      if (ad_err[16]) ad_sum = ad_sum + 17'(ADAPT_STEP);
      else            ad_sum = ad_sum - 17'(ADAPT_STEP);
    end
    if (ad_sum[16] != ad_sum[15]) sup_wdata = ad_sum[16] ? 16'sh8000 : 16'sh7fff;
    else                          sup_wdata = ad_sum[15:0];
  end

  assign sup_we    = (state_r == S_AD);
  assign avg_we    = (state_r == S_AVG_DIV) && div_rsp.done;
  assign avg_wdata = div_rsp.quo[15:0];

  always_ff @(posedge clk) begin
    if (sup_we) sup_mem[addr_r] <= sup_wdata;
    if (avg_we) avg_mem[addr_r] <= avg_wdata;
    sup_rd_r  <= sup_mem[addr_r];
    avg_rd_r  <= avg_mem[addr_r];
    rd_addr_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_vld_r    <= '0;
      seen_r       <= '0;
      sup_vld_rd_r <= 1'b0;
      seen_rd_r    <= 1'b0;
    end else begin
      if (sup_we) sup_vld_r[addr_r] <= 1'b1;
      if (avg_we) seen_r[addr_r] <= 1'b1;
      sup_vld_rd_r <= sup_vld_r[addr_r];
      seen_rd_r    <= seen_r[addr_r];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_AUTO;
      setpoint_r <= 16'sd4736;
      hyst_r     <= 15'd512;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:     mode_r <= mode_t'(cfg_wdata[0]);
        REG_SETPOINT: setpoint_r <= cfg_wdata;
        REG_HYST:     hyst_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // datapath terms for the divider and the valve decision
  logic signed [28:0] seg_sum;
  logic signed [16:0] seg_dx;
  dnum_t seg_num, avg_base, avg_num, red_num, ind_ext;
  logic signed [16:0] red_diff, v_err, v_mag;
  temp_t avg_seed;

  always_comb begin
    seg_sum  = prod_r + 29'sd640;
    seg_num  = {{3{seg_sum[28]}}, seg_sum[28:8]};
    seg_dx   = {outd_r[15], outd_r} - {1'b0, 16'h0} -
               17'(signed'(breakpoint(pos_idx - IDX_W'(1))));
    avg_seed = seen_rd_r ? avg_rd_r : ind_r;
    avg_base = {{8{avg_seed[15]}}, avg_seed};
    ind_ext  = {{8{ind_r[15]}}, ind_r};
    avg_num  = (avg_base <<< 6) + (avg_base <<< 4) + ind_ext + 24'sd40;
    red_diff = {target_r[15], target_r} - {last_r[15], last_r};
    red_num  = {{7{red_diff[16]}}, red_diff};
    red_num  = (red_num <<< 1) + red_num + 24'sd5;
    v_err    = {sup_meas_r[15], sup_meas_r} - {reduced_r[15], reduced_r};
    v_mag    = v_err[16] ? -v_err : v_err;
  end

  // divider start: segment, average, and the morning reduction
  assign div_go = (state_r == S_SEG_GO) || (state_r == S_AVG) ||
                  ((state_r == S_RED) && morning);

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      div_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      div_req_r.start <= div_go;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            outd_r     <= in_outdoor_temp;
            ind_r      <= in_indoor_temp;
            sup_meas_r <= in_supply_temp;
            hour_r     <= in_hour_of_day;
            pos_r      <= below_cnt;
            if (req_t'(in_req_type) == REQ_ADAPT) begin
              addr_r  <= '0;
              state_r <= S_AD_W;
            end else if (mode_r == MODE_MANUAL) begin
              step_r    <= VALVE_NONE;
              reduced_r <= '0;
              acted_r   <= 1'b0;
              state_r   <= S_DONE;
            end else begin
              addr_r  <= IDX_W'(CURVE_POINTS - 1);
              state_r <= S_LAST_W;
            end
          end
        end
        S_LAST_W: state_r <= S_LAST;
        S_LAST: begin
          last_r <= sup_rd;
          if (above) begin
            target_r <= sup_rd;   // clamp above the curve, no average update
            state_r  <= S_RED;
          end else begin
            addr_r  <= (pos_idx == '0) ? '0 : pos_idx - IDX_W'(1);
            state_r <= S_A_W;
          end
        end
        S_A_W: state_r <= S_A;
        S_A: begin
          y1_r   <= sup_rd;
          addr_r <= pos_idx;
          if (pos_idx == '0) begin
            target_r <= sup_rd;
            state_r  <= S_AVG_W;
          end else begin
            state_r <= S_B_W;
          end
        end
        S_B_W: state_r <= S_B;
        S_B: begin
          dy_r    <= {sup_rd[15], sup_rd} - {y1_r[15], y1_r};
          dx_r    <= seg_dx[10:0];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= signed'({1'b0, dx_r}) * dy_r;
          state_r <= S_SEG_GO;
        end
        S_SEG_GO: begin
          div_req_r.den <= DEN_SEG;
          div_req_r.num <= seg_num;
          state_r       <= S_SEG_DIV;
        end
        S_SEG_DIV: begin
          if (div_rsp.done) begin
            target_r <= y1_r + div_rsp.quo[15:0];
            state_r  <= S_AVG_W;
          end
        end
        S_AVG_W: state_r <= S_AVG;
        S_AVG: begin
          div_req_r.den <= DEN_AVG;
          div_req_r.num <= avg_num;
          state_r       <= S_AVG_DIV;
        end
        S_AVG_DIV: if (div_rsp.done) state_r <= S_RED;
        S_RED: begin
          if (morning) begin
            div_req_r.den <= DEN_RED;
            div_req_r.num <= red_num;
            state_r       <= S_RED_DIV;
          end else begin
            reduced_r <= target_r;
            state_r   <= S_VALVE;
          end
        end
        S_RED_DIV: begin
          if (div_rsp.done) begin
            reduced_r <= target_r - div_rsp.quo[15:0];
            state_r   <= S_VALVE;
          end
        end
        S_VALVE: begin
          if (v_mag > signed'({2'b00, hyst_r}))
            step_r <= v_err[16] ? VALVE_UP : VALVE_DOWN;
          else
            step_r <= VALVE_NONE;
          acted_r <= 1'b1;
          state_r <= S_DONE;
        end
        S_AD_W: state_r <= S_AD;
        S_AD: begin
          if (addr_r == IDX_W'(CURVE_POINTS - 1)) begin
            step_r    <= VALVE_NONE;
            reduced_r <= '0;
            acted_r   <= 1'b0;
            state_r   <= S_DONE;
          end else begin
            addr_r  <= addr_r + IDX_W'(1);
            state_r <= S_AD_W;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_step_r   <= step_r;
            out_target_r <= reduced_r;
            out_acted_r  <= acted_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valve_step    = out_step_r;
  assign out_supply_target = out_target_r;
  assign out_acted         = out_acted_r;

  // helper terms for the checks below
  logic noact_ok, step_bad;
  assign noact_ok = (out_step_r == VALVE_NONE) && (out_target_r == 16'sd0);
  assign step_bad = (out_step_r != VALVE_NONE) && (out_step_r != VALVE_UP) &&
                    (out_step_r != VALVE_DOWN);

  `HCSC_ASSERT(a_idle_div_quiet, (state_r == S_IDLE) |-> !div_rsp.busy, "divider busy in idle")
  `HCSC_ASSERT(a_noact_zero, (out_valid_r && !out_acted_r) |-> noact_ok, "idle result not zero")
  `HCSC_NEVER(a_step_code, out_valid_r && step_bad, "bad valve code")
  `HCSC_NEVER(a_two_writes, sup_we && avg_we, "both curve RAMs written at once")

endmodule
